>>> rtl/irt_pkg.sv
// ----------------------------------------------------------------------------
// irt_pkg
// Shared constants for the interval reservation table: port widths,
// parameter defaults and result status codes.
// ----------------------------------------------------------------------------
package irt_pkg;

    // Port widths fixed by the request and result formats
    localparam int TIME_PORT_W  = 16;
    localparam int COUNT_PORT_W = 7;
    localparam int STATUS_W     = 2;

    // Parameter defaults
    localparam int MAX_INTERVALS_DEF = 64;
    localparam int TIME_BITS_DEF     = 16;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_ACCEPT   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CONFLICT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

endpackage

>>> rtl/interval_reservation_table.sv
// ----------------------------------------------------------------------------
// interval_reservation_table
// Stores up to MAX_INTERVALS half-open intervals and checks each request
// against all of them for overlap before storing it.
// ----------------------------------------------------------------------------
// A request [start, end) is compared with every stored interval [s, e) using
// s < end && start < e. Any overlap gives a conflict status; otherwise the
// request is stored in the next free slot, or refused with a full status if
// all slots are in use. The single read port of the slot memory issues one
// slot read per cycle, each slot is compared in the cycle after its read as
// the next read goes out, and the finish state then writes back and loads
// the result; a stalled output holds the finish state until it is free.
// Slots are never freed, so the stored intervals always occupy slots 0 to
// count-1 and the fill count alone marks them valid; no clearing pass
// follows reset. One request is in work at a time, and a new request may
// transfer in while the previous result still waits at the output.
// ----------------------------------------------------------------------------
module interval_reservation_table #(
    parameter int MAX_INTERVALS = irt_pkg::MAX_INTERVALS_DEF,
    parameter int TIME_BITS     = irt_pkg::TIME_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [irt_pkg::TIME_PORT_W-1:0]  i_start_time,
    input  logic [irt_pkg::TIME_PORT_W-1:0]  i_end_time,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [irt_pkg::STATUS_W-1:0]     o_status,
    output logic [irt_pkg::COUNT_PORT_W-1:0] o_stored_count
);

    // Effective time width: the port width caps the stored width
    localparam int TW    = (TIME_BITS < irt_pkg::TIME_PORT_W) ? TIME_BITS
                                                               : irt_pkg::TIME_PORT_W;
    localparam int IDX_W = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int CNT_W = $clog2(MAX_INTERVALS + 1);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    // Slot memory: {start, end} per entry, one write and one read port
    logic [2*TW-1:0] slot_mem [MAX_INTERVALS];

    t_state          r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_addr, n_addr;
    logic            r_rd_pend, n_rd_pend;
    logic            r_hit, n_hit;
    logic [TW-1:0]   r_req_s, r_req_e;
    logic [2*TW-1:0] r_rd_data;

    logic                             r_out_valid, n_out_valid;
    logic [irt_pkg::STATUS_W-1:0]     r_status, n_status;
    logic [CNT_W-1:0]                 r_out_count, n_out_count;

    logic             w_in_xfer;
    logic             w_out_free;
    logic             w_rd_en;
    logic [IDX_W-1:0] w_rd_addr;
    logic             w_wr_en;
    logic [TW-1:0]    w_mem_s, w_mem_e;
    logic             w_overlap;
    logic             w_full;
    logic [CNT_W+irt_pkg::COUNT_PORT_W-1:0] w_cnt_ext;

    assign w_in_xfer  = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_mem_s    = r_rd_data[2*TW-1:TW];
    assign w_mem_e    = r_rd_data[TW-1:0];
    assign w_overlap  = (w_mem_s < r_req_e) && (r_req_s < w_mem_e);
    assign w_full     = (r_count >= CNT_W'(MAX_INTERVALS));

    // Sequence the scan, the write-back and the result load
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_addr      = r_addr;
        n_rd_pend   = 1'b0;
        n_hit       = r_hit;
        n_out_valid = r_out_valid && i_out_stall;
        n_status    = r_status;
        n_out_count = r_out_count;
        w_rd_en     = 1'b0;
        w_rd_addr   = r_addr[IDX_W-1:0];
        w_wr_en     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_hit = 1'b0;
                    if (r_count == '0) begin
                        n_state = S_FINISH;
                    end else begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = '0;
                        n_addr    = CNT_W'(1);
                        n_rd_pend = 1'b1;
                        n_state   = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // compare the slot read last cycle, issue the next read
                n_hit = r_hit || (r_rd_pend && w_overlap);
                if (r_addr < r_count) begin
                    w_rd_en   = 1'b1;
                    n_addr    = r_addr + CNT_W'(1);
                    n_rd_pend = 1'b1;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                // write back and load the result once the output is free
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (r_hit) begin
                        n_status = irt_pkg::ST_CONFLICT;
                    end else if (w_full) begin
                        n_status = irt_pkg::ST_FULL;
                    end else begin
                        n_status = irt_pkg::ST_ACCEPT;
                        w_wr_en  = 1'b1;
                        n_count  = r_count + CNT_W'(1);
                    end
                    n_out_count = n_count;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_addr      <= '0;
            r_rd_pend   <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_addr      <= n_addr;
            r_rd_pend   <= n_rd_pend;
            r_hit       <= n_hit;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold the request and the result payload
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_req_s <= i_start_time[TW-1:0];
            r_req_e <= i_end_time[TW-1:0];
        end
        r_status    <= n_status;
        r_out_count <= n_out_count;
    end

    // Slot memory ports; writes fall only in the finish state, so a read
    // never meets a write to the same entry
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            slot_mem[r_count[IDX_W-1:0]] <= {r_req_s, r_req_e};
        end
        if (w_rd_en) begin
            r_rd_data <= slot_mem[w_rd_addr];
        end
    end

    assign w_cnt_ext      = {{irt_pkg::COUNT_PORT_W{1'b0}}, r_out_count};
    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_stored_count = w_cnt_ext[irt_pkg::COUNT_PORT_W-1:0];

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_INTERVALS))
        else $error("fill count beyond table depth");

    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_count != '0))
        else $error("scan started on an empty table");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == irt_pkg::ST_FULL)) |->
        (r_out_count == CNT_W'(MAX_INTERVALS)))
        else $error("full status with free slots");

    a_accept_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && w_out_free && !r_hit && !w_full) |=>
        (r_count == $past(r_count) + CNT_W'(1)))
        else $error("accepted request not counted");

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for interval_reservation_table. Sends directed and
// random reservation requests over the valid/stall request channel and keeps
// its own copy of the stored intervals, which predicts the status and the
// stored count for each request. Every result is checked against the oldest
// prediction, and both sides idle at random in all but the last of three phases.
// ----------------------------------------------------------------------------
module tb;

    localparam int SLOTS        = irt_pkg::MAX_INTERVALS_DEF;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = SLOTS + 16;

    typedef struct packed {
        logic [irt_pkg::STATUS_W-1:0]     status;
        logic [irt_pkg::COUNT_PORT_W-1:0] count;
    } t_booking_result;

    logic                             clk            = 1'b0;
    logic                             rst_n          = 1'b0;
    logic                             in_valid       = 1'b0;
    logic                             in_stall;
    logic [irt_pkg::TIME_PORT_W-1:0]  start_time     = '0;
    logic [irt_pkg::TIME_PORT_W-1:0]  end_time       = '0;
    logic                             out_valid;
    logic                             out_stall      = 1'b0;
    logic [irt_pkg::STATUS_W-1:0]     status;
    logic [irt_pkg::COUNT_PORT_W-1:0] stored_count;

    // Predicted contents of the reservation store
    logic [irt_pkg::TIME_PORT_W-1:0]  held_start [SLOTS];
    logic [irt_pkg::TIME_PORT_W-1:0]  held_end   [SLOTS];
    int                               held_count = 0;

    t_booking_result         pending_results [$];
    int                      error_count        = 0;
    int                      cycle_count        = 0;
    int                      sender_idle_pct    = 0;
    int                      receiver_stall_pct = 0;

    interval_reservation_table u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_start_time   (start_time),
        .i_end_time     (end_time),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_status       (status),
        .o_stored_count (stored_count)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // Time out a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Stall the result channel at random
    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // Print one line per mismatch and count them all
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d (cycle %0d)",
                 what, got, want, cycle_count);
        error_count++;
    endtask

    // Test the request against every held interval, then store it if it fits
    function automatic t_booking_result book_interval(
            input logic [irt_pkg::TIME_PORT_W-1:0] s,
            input logic [irt_pkg::TIME_PORT_W-1:0] e);
        t_booking_result res;
        bit              clash;
        clash = 1'b0;
        for (int k = 0; k < held_count; k++) begin
            if (held_start[k] < e && s < held_end[k])
                clash = 1'b1;
        end
        if (clash) begin
            res.status = irt_pkg::ST_CONFLICT;
        end else if (held_count >= SLOTS) begin
            res.status = irt_pkg::ST_FULL;
        end else begin
            held_start[held_count] = s;
            held_end[held_count]   = e;
            held_count++;
            res.status = irt_pkg::ST_ACCEPT;
        end
        res.count = held_count[irt_pkg::COUNT_PORT_W-1:0];
        return res;
    endfunction

    // Drive one request, hold it until the transfer, then predict its result
    task automatic send_request(input logic [irt_pkg::TIME_PORT_W-1:0] s,
                                input logic [irt_pkg::TIME_PORT_W-1:0] e);
        if ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
        end
        in_valid   <= 1'b1;
        start_time <= s;
        end_time   <= e;
        do @(posedge clk); while (in_stall);
        pending_results.push_back(book_interval(s, e));
    endtask

    // Check each result transfer against the oldest prediction
    always @(posedge clk) begin : check_results
        t_booking_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", status, -1);
            end else begin
                want = pending_results.pop_front();
                if (status !== want.status)
                    report_mismatch("status", status, want.status);
                if (stored_count !== want.count)
                    report_mismatch("stored_count", stored_count, want.count);
            end
        end
    end

    // Abutting intervals pass, any shared point is a conflict
    task automatic test_overlap_rule();
        send_request(16'd100, 16'd200);
        send_request(16'd199, 16'd300);
        send_request(16'd200, 16'd300);
        send_request(16'd50,  16'd100);
        send_request(16'd99,  16'd101);
        send_request(16'd0,   16'hFFFF);
    endtask

    // Empty and reversed requests go through the same rule
    task automatic test_empty_and_reversed();
        send_request(16'd150,  16'd150);
        send_request(16'd300,  16'd300);
        send_request(16'd1000, 16'd500);
        send_request(16'd400,  16'd1100);
        send_request(16'd600,  16'd900);
        send_request(16'd2000, 16'd2000);
    endtask

    // Edges of the time range and alternating bit patterns
    task automatic test_time_extremes();
        send_request(16'd0,    16'd0);
        send_request(16'hFFFF, 16'hFFFF);
        send_request(16'hFFFE, 16'hFFFF);
        send_request(16'hFFFF, 16'd0);
        send_request(16'h5555, 16'hAAAA);
        send_request(16'hAAAA, 16'h5555);
        send_request(16'hAAAA, 16'hAAAB);
    endtask

    // Mostly short intervals so the store fills, plus wide, empty, reversed,
    // duplicate and abutting requests to reach both conflict and full
    function automatic void pick_request(output logic [irt_pkg::TIME_PORT_W-1:0] s,
                                         output logic [irt_pkg::TIME_PORT_W-1:0] e);
        int                              kind;
        int                              k;
        logic [irt_pkg::TIME_PORT_W:0]   top;
        logic [irt_pkg::TIME_PORT_W-1:0] a;
        logic [irt_pkg::TIME_PORT_W-1:0] b;
        kind = $urandom_range(99);
        a    = 16'($urandom);
        b    = 16'($urandom);
        if (kind < 50) begin
            s   = a;
            top = {1'b0, a} + 17'($urandom_range(1, 48));
            e   = top[irt_pkg::TIME_PORT_W] ? 16'hFFFF
                                            : top[irt_pkg::TIME_PORT_W-1:0];
        end else if (kind < 65) begin
            s = (a < b) ? a : b;
            e = (a < b) ? b : a;
        end else if (kind < 75) begin
            s = a;
            e = a;
        end else if (kind < 85) begin
            s = (a > b) ? a : b;
            e = (a > b) ? b : a;
        end else if (held_count == 0) begin
            s = a;
            e = b;
        end else begin
            k = $urandom_range(held_count - 1);
            if ($urandom_range(1)) begin
                s = held_start[k];
                e = held_end[k];
            end else begin
                s = held_end[k];
                e = held_end[k] + 16'($urandom_range(16));
            end
        end
    endfunction

    task automatic test_random_requests(input int n, input int sidle, input int rstall);
        logic [irt_pkg::TIME_PORT_W-1:0] s;
        logic [irt_pkg::TIME_PORT_W-1:0] e;
        sender_idle_pct    = sidle;
        receiver_stall_pct = rstall;
        repeat (n) begin
            pick_request(s, e);
            send_request(s, e);
        end
    endtask

    initial begin
        sender_idle_pct    = 13;
        receiver_stall_pct = 73;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_overlap_rule();
        test_empty_and_reversed();
        test_time_extremes();
        test_random_requests(262, 13, 73);
        test_random_requests(262, 73, 13);
        test_random_requests(262, 0, 0);

        // Release the request channel and let the last results drain
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> sim.f
rtl/irt_pkg.sv
rtl/interval_reservation_table.sv
test/tb.sv
